FILE: design/tlfs_pkg.sv
// ----------------------------------------------------------------------------
// tlfs_pkg: shared codes for the two-level feedback scheduler
// Result outcome codes, queue selects, device codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package tlfs_pkg;

  // Result outcome codes.
  localparam logic [2:0] OUT_ADMIT    = 3'd0;
  localparam logic [2:0] OUT_REJECT   = 3'd1;
  localparam logic [2:0] OUT_IDLE     = 3'd2;
  localparam logic [2:0] OUT_RAN      = 3'd3;
  localparam logic [2:0] OUT_FINISH   = 3'd4;
  localparam logic [2:0] OUT_TO_IO    = 3'd5;
  localparam logic [2:0] OUT_PREEMPT  = 3'd6;

  // Queue selects; they also form the upper bits of the queue memory address.
  localparam logic [1:0] RING_HIGH = 2'd0;
  localparam logic [1:0] RING_LOW  = 2'd1;
  localparam logic [1:0] RING_IO   = 2'd2;

  // Device codes. Any code other than disk or tape behaves as printer.
  localparam logic [1:0] DEV_DISK = 2'd0;
  localparam logic [1:0] DEV_TAPE = 2'd1;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUANTUM_HIGH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_QUANTUM_LOW  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DISK_TICKS   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TAPE_TICKS   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRINT_TICKS  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [7:0] RST_QUANTUM_HIGH = 8'd2;
  localparam logic [7:0] RST_QUANTUM_LOW  = 8'd4;
  localparam logic [7:0] RST_DISK_TICKS   = 8'd5;
  localparam logic [7:0] RST_TAPE_TICKS   = 8'd3;
  localparam logic [7:0] RST_PRINT_TICKS  = 8'd4;

endpackage

`default_nettype wire

FILE: design/tlfs_ram.sv
// ----------------------------------------------------------------------------
// tlfs_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tlfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/two_level_feedback_scheduler.sv
// ----------------------------------------------------------------------------
// two_level_feedback_scheduler: two-level feedback round-robin scheduler
// Admits tasks into a high queue and, per tick, counts down the I/O queue,
// dispatches, runs one unit of the current task and advances the clock.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    action, burst_length, io_request,
//                                             io_device
// out       output     out_valid / out_ready  outcome, task_index, wait_time,
//                                             turnaround, io_completions,
//                                             tick_number
// cfg       input      cfg_write              cfg_index, cfg_data
//
// For a tick request, a sequencer walks the I/O queue one entry at a time
// through the simple dual-port queue and task memories. Reset is synchronous;
// memories need no clearing, so the block is ready in the cycle after reset.
// in_ready is high only while no request is in work; a result waiting on
// out_ready stalls only the end of the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module two_level_feedback_scheduler
  import tlfs_pkg::*;
#(
  parameter int MAX_TASKS  = 64,
  parameter int RING_DEPTH = 64,
  parameter int TIME_BITS  = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   action,
  input  wire logic [15:0]            burst_length,
  input  wire logic                   io_request,
  input  wire logic [1:0]             io_device,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [2:0]                  outcome,
  output logic [5:0]                  task_index,
  output logic [15:0]                 wait_time,
  output logic [15:0]                 turnaround,
  output logic [6:0]                  io_completions,
  output logic [15:0]                 tick_number,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]             cfg_data
);

  localparam int TW      = $clog2(MAX_TASKS);
  localparam int TCW     = $clog2(MAX_TASKS + 1);
  localparam int PW      = $clog2(RING_DEPTH);
  localparam int CW      = $clog2(RING_DEPTH + 1);
  localparam int RR_AW   = PW + 2;
  localparam int RR_DEPTH = 4 << PW;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_IO_RD  = 4'd1;
  localparam logic [3:0] S_IO_T   = 4'd2;
  localparam logic [3:0] S_IO_W   = 4'd3;
  localparam logic [3:0] S_DISP   = 4'd4;
  localparam logic [3:0] S_DISP_T = 4'd5;
  localparam logic [3:0] S_DISP_W = 4'd6;
  localparam logic [3:0] S_RUN_RD = 4'd7;
  localparam logic [3:0] S_RUN_L  = 4'd8;
  localparam logic [3:0] S_RUN    = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  typedef struct packed {
    logic [15:0]          rem;
    logic [15:0]          acc;
    logic [TIME_BITS-1:0] since;
    logic [TIME_BITS-1:0] arr;
    logic [1:0]           dev;
    logic [7:0]           cd;
  } entry_t;

  localparam int EW = $bits(entry_t);

  function automatic logic [15:0] diff16(input logic [TIME_BITS-1:0] a,
                                         input logic [TIME_BITS-1:0] b);
    diff16 = 16'(a) - 16'(b);
  endfunction

  // Configuration registers.
  logic [7:0] quantum_high, quantum_low, disk_ticks, tape_ticks, print_ticks;

  // Control and working registers.
  logic [3:0]           state, state_next;
  logic                 running_valid, running_valid_next;
  logic [TW-1:0]        run_t, run_t_next;
  logic [7:0]           slice_left, slice_left_next;
  logic [TIME_BITS-1:0] now_time, now_time_next;
  logic [TCW-1:0]       task_count, task_count_next;
  logic [PW-1:0]        head [3];
  logic [PW-1:0]        head_next [3];
  logic [CW-1:0]        cnt [3];
  logic [CW-1:0]        cnt_next [3];
  logic                 io_req_q, io_req_q_next;
  logic [1:0]           dev_q, dev_q_next;
  logic [1:0]           src, src_next;
  logic [CW-1:0]        n_q, n_q_next;
  logic [CW-1:0]        i_q, i_q_next;
  logic [CW-1:0]        compl_q, compl_q_next;
  logic [TW-1:0]        cur_t, cur_t_next;
  entry_t               ent, ent_next;
  logic [2:0]           res_outcome, res_outcome_next;
  logic [5:0]           res_task, res_task_next;
  logic [15:0]          res_wait, res_wait_next;
  logic [15:0]          res_turn, res_turn_next;
  logic [15:0]          res_tick, res_tick_next;
  logic                 out_valid_next;
  logic                 out_load;

  // Memory ports.
  logic              t_we;
  logic [TW-1:0]     t_waddr, t_raddr;
  entry_t            t_wdata, t_rdata;
  logic              r_we;
  logic [RR_AW-1:0]  r_waddr, r_raddr;
  logic [TW-1:0]     r_rdata;

  // Queue pointer unit requests.
  logic          push_en, pop_en;
  logic [1:0]    push_sel, pop_sel, op_sel;
  logic [TW-1:0] push_task;
  logic [PW-1:0] sel_head;
  logic [CW-1:0] sel_cnt;
  logic [PW:0]   tail_sum;
  logic [PW-1:0] tail;
  logic [PW-1:0] head_inc;

  entry_t        e;
  logic [7:0]    q;
  logic [7:0]    sl;

  tlfs_ram #(.WIDTH(EW), .DEPTH(MAX_TASKS)) u_task_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  tlfs_ram #(.WIDTH(TW), .DEPTH(RR_DEPTH)) u_ring_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (push_task),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  assign in_ready = (state == S_IDLE);

  // Sequencer: next state, working values and memory requests.
  always_comb begin
    state_next         = state;
    running_valid_next = running_valid;
    run_t_next         = run_t;
    slice_left_next    = slice_left;
    now_time_next      = now_time;
    task_count_next    = task_count;
    io_req_q_next      = io_req_q;
    dev_q_next         = dev_q;
    src_next           = src;
    n_q_next           = n_q;
    i_q_next           = i_q;
    compl_q_next       = compl_q;
    cur_t_next         = cur_t;
    ent_next           = ent;
    res_outcome_next   = res_outcome;
    res_task_next      = res_task;
    res_wait_next      = res_wait;
    res_turn_next      = res_turn;
    res_tick_next      = res_tick;
    out_load           = 1'b0;
    t_we               = 1'b0;
    t_waddr            = cur_t;
    t_wdata            = ent;
    t_raddr            = cur_t;
    r_raddr            = {RING_HIGH, head[RING_HIGH]};
    push_en            = 1'b0;
    push_sel           = RING_HIGH;
    push_task          = cur_t;
    pop_en             = 1'b0;
    pop_sel            = RING_HIGH;
    e                  = t_rdata;
    q                  = 8'd1;
    sl                 = slice_left;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_tick_next  = 16'(now_time);
          res_task_next  = 6'd0;
          res_wait_next  = 16'd0;
          res_turn_next  = 16'd0;
          compl_q_next   = '0;
          if (action) begin
            if (burst_length == 16'd0 || task_count >= TCW'(MAX_TASKS) ||
                cnt[RING_HIGH] >= CW'(RING_DEPTH)) begin
              res_outcome_next = OUT_REJECT;
            end else begin
              e.rem   = burst_length;
              e.acc   = 16'd0;
              e.since = now_time;
              e.arr   = now_time;
              e.dev   = DEV_DISK;
              e.cd    = 8'd0;
              t_we    = 1'b1;
              t_waddr = task_count[TW-1:0];
              t_wdata = e;
              push_en   = 1'b1;
              push_sel  = RING_HIGH;
              push_task = task_count[TW-1:0];
              task_count_next  = task_count + TCW'(1);
              res_outcome_next = OUT_ADMIT;
              res_task_next    = 6'(task_count);
            end
            state_next = S_FIN;
          end else begin
            io_req_q_next = io_request;
            dev_q_next    = io_device;
            n_q_next      = cnt[RING_IO];
            i_q_next      = '0;
            state_next    = (cnt[RING_IO] != '0) ? S_IO_RD : S_DISP;
          end
        end
      end

      // Walk the I/O queue: read slot, read task, update and requeue.
      S_IO_RD: begin
        r_raddr    = {RING_IO, head[RING_IO]};
        state_next = S_IO_T;
      end

      S_IO_T: begin
        t_raddr    = r_rdata;
        cur_t_next = r_rdata;
        pop_en     = 1'b1;
        pop_sel    = RING_IO;
        state_next = S_IO_W;
      end

      S_IO_W: begin
        e = t_rdata;
        push_en   = 1'b1;
        push_task = cur_t;
        if (e.cd > 8'd1) begin
          e.cd     = e.cd - 8'd1;
          push_sel = RING_IO;
        end else begin
          e.cd         = 8'd0;
          e.since      = now_time;
          compl_q_next = compl_q + CW'(1);
          push_sel     = (e.dev == DEV_DISK) ? RING_LOW : RING_HIGH;
        end
        t_we     = 1'b1;
        t_waddr  = cur_t;
        t_wdata  = e;
        i_q_next = i_q + CW'(1);
        state_next = (i_q + CW'(1) == n_q) ? S_DISP : S_IO_RD;
      end

      // Dispatch from the high queue first, then the low queue.
      S_DISP: begin
        if (running_valid) begin
          state_next = S_RUN_RD;
        end else if (cnt[RING_HIGH] != '0) begin
          src_next        = RING_HIGH;
          slice_left_next = (quantum_high == 8'd0) ? 8'd1 : quantum_high;
          r_raddr         = {RING_HIGH, head[RING_HIGH]};
          state_next      = S_DISP_T;
        end else if (cnt[RING_LOW] != '0) begin
          src_next        = RING_LOW;
          slice_left_next = (quantum_low == 8'd0) ? 8'd1 : quantum_low;
          r_raddr         = {RING_LOW, head[RING_LOW]};
          state_next      = S_DISP_T;
        end else begin
          res_outcome_next = OUT_IDLE;
          res_task_next    = 6'd0;
          res_wait_next    = 16'd0;
          res_turn_next    = 16'd0;
          now_time_next    = now_time + TIME_BITS'(1);
          state_next       = S_FIN;
        end
      end

      S_DISP_T: begin
        t_raddr    = r_rdata;
        run_t_next = r_rdata;
        pop_en     = 1'b1;
        pop_sel    = src;
        state_next = S_DISP_W;
      end

      S_DISP_W: begin
        e     = t_rdata;
        e.acc = e.acc + diff16(now_time, e.since);
        q     = slice_left;
        if (e.rem < 16'(q)) begin
          q = e.rem[7:0];
        end
        slice_left_next    = q;
        ent_next           = e;
        running_valid_next = 1'b1;
        state_next         = S_RUN;
      end

      S_RUN_RD: begin
        t_raddr    = run_t;
        state_next = S_RUN_L;
      end

      S_RUN_L: begin
        ent_next   = t_rdata;
        state_next = S_RUN;
      end

      // Run one unit of the current task.
      S_RUN: begin
        e  = ent;
        e.rem = e.rem - 16'd1;
        sl = slice_left - 8'd1;
        slice_left_next = sl;
        res_task_next   = 6'(run_t);
        res_wait_next   = 16'd0;
        res_turn_next   = 16'd0;
        push_task       = run_t;
        if (e.rem == 16'd0) begin
          res_outcome_next   = OUT_FINISH;
          res_wait_next      = e.acc;
          res_turn_next      = diff16(now_time, e.arr);
          running_valid_next = 1'b0;
        end else if (io_req_q) begin
          e.dev = dev_q;
          if (dev_q == DEV_DISK) begin
            e.cd = disk_ticks;
          end else if (dev_q == DEV_TAPE) begin
            e.cd = tape_ticks;
          end else begin
            e.cd = print_ticks;
          end
          push_en            = 1'b1;
          push_sel           = RING_IO;
          res_outcome_next   = OUT_TO_IO;
          running_valid_next = 1'b0;
        end else if (sl == 8'd0) begin
          e.since            = now_time;
          push_en            = 1'b1;
          push_sel           = RING_LOW;
          res_outcome_next   = OUT_PREEMPT;
          running_valid_next = 1'b0;
        end else begin
          res_outcome_next = OUT_RAN;
        end
        t_we          = 1'b1;
        t_waddr       = run_t;
        t_wdata       = e;
        now_time_next = now_time + TIME_BITS'(1);
        state_next    = S_FIN;
      end

      // Hand the result to the output register once it is free.
      S_FIN: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Queue pointer unit: one push or one pop per cycle.
  always_comb begin
    op_sel   = push_en ? push_sel : pop_sel;
    sel_head = head[op_sel];
    sel_cnt  = cnt[op_sel];
    tail_sum = (PW + 1)'(sel_head) + (PW + 1)'(sel_cnt);
    if (tail_sum >= (PW + 1)'(RING_DEPTH)) begin
      tail_sum = tail_sum - (PW + 1)'(RING_DEPTH);
    end
    tail = tail_sum[PW-1:0];
    head_inc = (sel_head == PW'(RING_DEPTH - 1)) ? '0 : sel_head + PW'(1);
    for (int k = 0; k < 3; k++) begin
      head_next[k] = head[k];
      cnt_next[k]  = cnt[k];
    end
    r_we    = 1'b0;
    r_waddr = {op_sel, tail};
    if (push_en) begin
      if (sel_cnt < CW'(RING_DEPTH)) begin
        r_we             = 1'b1;
        cnt_next[op_sel] = sel_cnt + CW'(1);
      end
    end else if (pop_en) begin
      head_next[op_sel] = head_inc;
      cnt_next[op_sel]  = sel_cnt - CW'(1);
    end
  end

  // Output register valid.
  always_comb begin
    out_valid_next = out_valid && !out_ready;
    if (out_load) begin
      out_valid_next = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running_valid <= 1'b0;
      run_t         <= '0;
      slice_left    <= 8'd0;
      now_time      <= '0;
      task_count    <= '0;
      out_valid     <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        head[k] <= '0;
        cnt[k]  <= '0;
      end
    end else begin
      state         <= state_next;
      running_valid <= running_valid_next;
      run_t         <= run_t_next;
      slice_left    <= slice_left_next;
      now_time      <= now_time_next;
      task_count    <= task_count_next;
      out_valid     <= out_valid_next;
      for (int k = 0; k < 3; k++) begin
        head[k] <= head_next[k];
        cnt[k]  <= cnt_next[k];
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    io_req_q    <= io_req_q_next;
    dev_q       <= dev_q_next;
    src         <= src_next;
    n_q         <= n_q_next;
    i_q         <= i_q_next;
    compl_q     <= compl_q_next;
    cur_t       <= cur_t_next;
    ent         <= ent_next;
    res_outcome <= res_outcome_next;
    res_task    <= res_task_next;
    res_wait    <= res_wait_next;
    res_turn    <= res_turn_next;
    res_tick    <= res_tick_next;
    if (out_load) begin
      outcome        <= res_outcome;
      task_index     <= res_task;
      wait_time      <= res_wait;
      turnaround     <= res_turn;
      io_completions <= 7'(compl_q);
      tick_number    <= res_tick;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum_high <= RST_QUANTUM_HIGH;
      quantum_low  <= RST_QUANTUM_LOW;
      disk_ticks   <= RST_DISK_TICKS;
      tape_ticks   <= RST_TAPE_TICKS;
      print_ticks  <= RST_PRINT_TICKS;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_QUANTUM_HIGH: quantum_high <= cfg_data;
        CFG_QUANTUM_LOW:  quantum_low  <= cfg_data;
        CFG_DISK_TICKS:   disk_ticks   <= cfg_data;
        CFG_TAPE_TICKS:   tape_ticks   <= cfg_data;
        CFG_PRINT_TICKS:  print_ticks  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Queue occupancy never exceeds the queue depth.
  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    cnt[RING_HIGH] <= CW'(RING_DEPTH) && cnt[RING_LOW] <= CW'(RING_DEPTH) &&
    cnt[RING_IO] <= CW'(RING_DEPTH))
    else $error("queue count above depth");

  // The task table never holds more tasks than it has entries.
  a_task_bound: assert property (@(posedge clk) disable iff (rst)
    task_count <= TCW'(MAX_TASKS))
    else $error("task count above table size");

  // An accepted request keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // The I/O walk never runs past the entries it started with.
  a_io_walk: assert property (@(posedge clk) disable iff (rst)
    state == S_IO_W |-> i_q < n_q)
    else $error("I/O walk overran");
`endif

endmodule

`default_nettype wire

FILE: verif/two_level_feedback_scheduler_tb.sv
// ----------------------------------------------------------------------------
// two_level_feedback_scheduler_tb: self-checking bench for the scheduler
// Drives admit and tick requests with random gaps and stalls, keeps its own
// model of the queues and task tables, and checks every result field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module two_level_feedback_scheduler_tb;
  import tlfs_pkg::*;

  localparam int NTASK = 64;
  localparam int DEPTH = 64;
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [5:0]  task_index;
    logic [15:0] wait_time;
    logic [15:0] turnaround;
    logic [6:0]  io_completions;
    logic [15:0] tick_number;
  } sched_result_t;

  // Queue model: fixed-depth rings of task numbers.
  typedef struct {
    logic [5:0] slot [DEPTH];
    int         head;
    int         count;
  } ring_t;

  // Scheduler model plus the queue of expected results.
  class sched_scoreboard;
    logic [7:0]  q_high, q_low, t_disk, t_tape, t_print;
    logic [15:0] remaining [NTASK];
    logic [15:0] waited [NTASK];
    logic [15:0] ready_at [NTASK];
    logic [15:0] arrived [NTASK];
    logic [1:0]  device_of [NTASK];
    logic [7:0]  countdown [NTASK];
    ring_t       high_q, low_q, io_q;
    bit          busy;
    logic [5:0]  cur;
    logic [7:0]  slice;
    logic [15:0] now;
    int          n_tasks;
    sched_result_t pending [$];
    int          errors;
    int          checked;
    int          finished_seen;

    function new();
      q_high = RST_QUANTUM_HIGH; q_low = RST_QUANTUM_LOW;
      t_disk = RST_DISK_TICKS; t_tape = RST_TAPE_TICKS; t_print = RST_PRINT_TICKS;
      high_q.head = 0; high_q.count = 0;
      low_q.head = 0; low_q.count = 0;
      io_q.head = 0; io_q.count = 0;
      busy = 0; cur = 0; slice = 0; now = 0; n_tasks = 0;
      errors = 0; checked = 0; finished_seen = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
      case (idx)
        CFG_QUANTUM_HIGH: q_high = val;
        CFG_QUANTUM_LOW:  q_low = val;
        CFG_DISK_TICKS:   t_disk = val;
        CFG_TAPE_TICKS:   t_tape = val;
        CFG_PRINT_TICKS:  t_print = val;
        default: ;
      endcase
    endfunction

    function void push(ref ring_t r, input logic [5:0] t);
      if (r.count < DEPTH) begin
        r.slot[(r.head + r.count) % DEPTH] = t;
        r.count++;
      end
    endfunction

    function logic [5:0] pop(ref ring_t r);
      logic [5:0] t;
      t = r.slot[r.head];
      r.head = (r.head + 1) % DEPTH;
      r.count--;
      return t;
    endfunction

    // Notes an accepted request and queues the result it must produce.
    function void note_request(logic act, logic [15:0] burst, logic ioreq,
                               logic [1:0] dev);
      sched_result_t r;
      int n;
      logic [5:0] t;
      logic [7:0] q;
      bit have_src;
      r = '0;
      r.tick_number = now;
      if (act) begin
        if (burst == 16'd0 || n_tasks >= NTASK || high_q.count >= DEPTH) begin
          r.outcome = OUT_REJECT;
        end else begin
          t = n_tasks[5:0];
          remaining[t] = burst; waited[t] = 16'd0;
          ready_at[t] = now; arrived[t] = now;
          push(high_q, t);
          n_tasks++;
          r.outcome = OUT_ADMIT;
          r.task_index = t;
        end
      end else begin
        // I/O countdown pass.
        n = io_q.count;
        for (int i = 0; i < n; i++) begin
          t = pop(io_q);
          if (countdown[t] > 8'd1) begin
            countdown[t]--;
            push(io_q, t);
          end else begin
            countdown[t] = 8'd0;
            ready_at[t] = now;
            r.io_completions++;
            if (device_of[t] == DEV_DISK) push(low_q, t);
            else push(high_q, t);
          end
        end
        // Dispatch when idle.
        if (!busy) begin
          have_src = 1;
          if (high_q.count > 0) begin
            t = pop(high_q); q = q_high;
          end else if (low_q.count > 0) begin
            t = pop(low_q); q = q_low;
          end else begin
            have_src = 0;
          end
          if (have_src) begin
            if (q == 8'd0) q = 8'd1;
            if (remaining[t] < 16'(q)) q = remaining[t][7:0];
            cur = t; busy = 1; slice = q;
            waited[t] = waited[t] + (now - ready_at[t]);
          end
        end
        // Run one unit.
        if (busy) begin
          t = cur;
          r.task_index = t;
          remaining[t] = remaining[t] - 16'd1;
          slice = slice - 8'd1;
          if (remaining[t] == 16'd0) begin
            r.outcome = OUT_FINISH;
            r.wait_time = waited[t];
            r.turnaround = now - arrived[t];
            busy = 0;
          end else if (ioreq) begin
            device_of[t] = dev;
            countdown[t] = (dev == DEV_DISK) ? t_disk :
                           (dev == DEV_TAPE) ? t_tape : t_print;
            push(io_q, t);
            r.outcome = OUT_TO_IO;
            busy = 0;
          end else if (slice == 8'd0) begin
            ready_at[t] = now;
            push(low_q, t);
            r.outcome = OUT_PREEMPT;
            busy = 0;
          end else begin
            r.outcome = OUT_RAN;
          end
        end else begin
          r.outcome = OUT_IDLE;
        end
        now = now + 16'd1;
      end
      pending.push_back(r);
    endfunction

    function void check_result(sched_result_t got);
      sched_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.outcome == OUT_FINISH) finished_seen++;
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d mismatch: expected %p, got %p", checked, want, got);
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, action, io_request, out_valid, out_ready;
  logic [15:0] burst_length;
  logic [1:0]  io_device;
  logic [2:0]  outcome;
  logic [5:0]  task_index;
  logic [15:0] wait_time, turnaround, tick_number;
  logic [6:0]  io_completions;
  logic        cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [7:0]  cfg_data;

  sched_scoreboard sb;
  int  send_idle_pct, recv_idle_pct;
  bit  recv_hold;
  int  quiet_cycles;
  int  requests_sent;

  two_level_feedback_scheduler i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .burst_length(burst_length),
    .io_request(io_request), .io_device(io_device),
    .out_valid(out_valid), .out_ready(out_ready),
    .outcome(outcome), .task_index(task_index), .wait_time(wait_time),
    .turnaround(turnaround), .io_completions(io_completions),
    .tick_number(tick_number),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
    rst = 1; in_valid = 0; action = 0; burst_length = 0; io_request = 0;
    io_device = 0; out_ready = 0; cfg_write = 0; cfg_index = CFG_QUANTUM_HIGH;
    cfg_data = 0; send_idle_pct = 0; recv_idle_pct = 0; recv_hold = 0;
    requests_sent = 0;
  end

  // Receiver: random stalls, or a long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready)
        sb.check_result('{outcome, task_index, wait_time, turnaround,
                          io_completions, tick_number});
    end
  end

  // Watchdog on cycles with no handshake.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", sb.pending.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Sends one request and notes it when accepted. Valid stays high after the
  // accept so that a following request can go out in the next cycle; the
  // block is busy then and does not take the old payload again.
  task automatic send_request(logic act, logic [15:0] burst, logic ioreq, logic [1:0] dev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; action <= act; burst_length <= burst;
    io_request <= ioreq; io_device <= dev;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_request(act, burst, ioreq, dev);
    requests_sent++;
  endtask

  task automatic tick(logic ioreq, logic [1:0] dev);
    send_request(1'b0, 16'd0, ioreq, dev);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
    cfg_write <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic write_all(logic [7:0] qh, logic [7:0] ql, logic [7:0] dk,
                           logic [7:0] tp, logic [7:0] pr);
    write_reg(CFG_QUANTUM_HIGH, qh);
    write_reg(CFG_QUANTUM_LOW, ql);
    write_reg(CFG_DISK_TICKS, dk);
    write_reg(CFG_TAPE_TICKS, tp);
    write_reg(CFG_PRINT_TICKS, pr);
    cfg_write <= 0;
  endtask

  // Random phase: a few admits mixed among mostly ticks with random I/O requests.
  // Bursts are mostly short so tasks finish and a 64-entry table lasts.
  task automatic random_phase(int n);
    logic [15:0] b;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 12) begin
        case ($urandom_range(9))
          0: b = 16'd0;
          1: b = 16'($urandom);
          default: b = 16'($urandom_range(1, 12));
        endcase
        send_request(1'b1, b, 1'($urandom), 2'($urandom));
      end else begin
        tick($urandom_range(99) < 30, 2'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: idle ticks, zero and maximal bursts, every outcome and device.
    tick(1'b0, DEV_DISK);
    send_request(1'b1, 16'd0, 1'b0, DEV_DISK);
    send_request(1'b1, 16'd1, 1'b0, DEV_DISK);
    send_request(1'b1, 16'd3, 1'b1, 2'd3);
    send_request(1'b1, 16'hFFFF, 1'b0, DEV_DISK);
    tick(1'b1, DEV_DISK);
    tick(1'b1, DEV_TAPE);
    tick(1'b1, 2'd2);
    tick(1'b0, DEV_DISK);
    tick(1'b0, DEV_DISK);
    tick(1'b1, 2'd3);
    repeat (8) tick(1'b0, DEV_DISK);
    drain();

    // Zero registers: quantum one and immediate I/O completion.
    write_all(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_request(1'b1, 16'd5, 1'b0, DEV_DISK);
    repeat (6) tick(1'b1, DEV_TAPE);
    drain();

    // Phase one: sender idles rarely, receiver often.
    write_all(8'd1, 8'd255, 8'd1, 8'd255, 8'd7);
    send_idle_pct = 6; recv_idle_pct = 83;
    random_phase(280);
    drain();

    // Receiver holds off while requests keep coming.
    fork
      begin
        recv_hold = 1;
        repeat (400) @(posedge clk);
        recv_hold = 0;
      end
      begin
        random_phase(20);
        in_valid <= 0;
        @(posedge clk);
      end
    join
    drain();

    // Phase two: roles swapped, values alternating between 255 and 1.
    write_all(8'd255, 8'd1, 8'd255, 8'd1, 8'd255);
    send_idle_pct = 83; recv_idle_pct = 6;
    random_phase(230);
    drain();

    // Phase three: no idling, random settings.
    write_all(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
              8'($urandom_range(1, 20)), 8'($urandom_range(1, 20)),
              8'($urandom_range(1, 20)));
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(300);
    drain();

    $display("Sent %0d requests over several register settings; %0d results checked,",
             requests_sent, sb.checked);
    $display("%0d task completions observed, %0d mismatches.", sb.finished_seen, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: two_level_feedback_scheduler.f
design/tlfs_pkg.sv
design/tlfs_ram.sv
design/two_level_feedback_scheduler.sv
verif/two_level_feedback_scheduler_tb.sv
